[design/short_float_merit_unit_top_assert.svh]
// Assertion macros used by the merit unit top.
// SFMU_ASSERT checks a property that is held off while reset is active.
// SFMU_ASSERT_ALWAYS checks a property at every clock edge, reset included.
`ifndef SHORT_FLOAT_MERIT_UNIT_TOP_ASSERT_SVH
`define SHORT_FLOAT_MERIT_UNIT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SFMU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define SFMU_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define SFMU_ASSERT(label, clk, rst_n, prop)

`define SFMU_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[design/sfmu_pkg.sv]
package sfmu_pkg;

    // Operation selected by the mode field of an input item.
    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_SHIFT = 2'd1,
        MODE_SCALE = 2'd2,
        MODE_ACCUM = 2'd3
    } t_mode;

    localparam logic [7:0] MAN_TOP_POS   = 8'd7;
    localparam logic [4:0] SCALE_MAX_AMT = 5'd26;
    localparam logic [4:0] SCALE_BIAS    = 5'd3;
    localparam logic [7:0] EXP_MAX       = 8'hFF;
    localparam logic [8:0] ACC_EXP_MAX   = 9'h1FF;

    // Index of the highest set bit of a 32-bit word, zero for zero.
    function automatic logic [4:0] top_bit32(input logic [31:0] x);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

    // Index of the highest set bit of a byte, zero for zero.
    function automatic logic [2:0] top_bit8(input logic [7:0] x);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (x[i]) begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

[design/short_float_merit_unit_top.sv]
// Short float merit unit.
// The block keeps a merit value as an 8-bit mantissa times 2^exponent and a
// long accumulator with a 32-bit mantissa and a 9-bit exponent. Each input
// transfer carries a mode (load, shift, scaled self add, accumulate), a
// 32-bit value and an 8-bit amount; each one yields exactly one output
// transfer with the merit, its integer log and the accumulator afterwards.
// Both channels use valid/ready. An accepted item is held in an input register,
// the execute logic (leading-one detectors, barrel shifters
// and 32-bit adders) updates the state, and the result lands in an output
// register. Throughput is one item per cycle while the receiver does not
// stall, set by the single execute stage that reads and writes the state.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more item; after that o_in_ready drops
// until the output moves. Synchronous active-low reset clears the merit
// and the accumulator to zero and empties both registers.
`include "short_float_merit_unit_top_assert.svh"

module short_float_merit_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_value,
    input  logic [7:0]  i_amount,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_merit_mantissa,
    output logic [7:0]  o_merit_exponent,
    output logic [8:0]  o_integer_log,
    output logic [31:0] o_sum_mantissa,
    output logic [8:0]  o_sum_exponent
);

    // Input register.
    logic               r_in_valid;
    sfmu_pkg::t_mode    r_in_mode;
    logic [31:0]        r_in_value;
    logic [7:0]         r_in_amount;

    // Architectural state.
    logic [7:0]  r_man, n_man;
    logic [7:0]  r_exp, n_exp;
    logic [31:0] r_acc_man, n_acc_man;
    logic [8:0]  r_acc_exp, n_acc_exp;

    // Output register.
    logic        r_out_valid;
    logic [7:0]  r_out_man;
    logic [7:0]  r_out_exp;
    logic [8:0]  r_out_ilog, n_ilog;
    logic [31:0] r_out_sum_man;
    logic [8:0]  r_out_sum_exp;

    logic in_fire;
    logic exec_fire;
    logic accum_fire;

    // The execute stage runs whenever it holds an item and the output
    // register is empty or being emptied in the same cycle.
    assign exec_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec_fire;
    assign in_fire    = i_in_valid && o_in_ready;
    assign accum_fire = exec_fire && (r_in_mode == sfmu_pkg::MODE_ACCUM);

    // Load: normalize the integer so that it fits in eight bits.
    logic [4:0]  ld_top;
    logic [4:0]  ld_sh;
    logic [7:0]  ld_man;

    // Shift: fill the mantissa up to bit 7, the rest goes to the exponent.
    logic [2:0]  m_top;
    logic [2:0]  sh_room;
    logic [2:0]  sh_k;
    logic [7:0]  sh_man;
    logic [8:0]  sh_exp_sum;
    logic [7:0]  sh_exp;

    // Scaled self add.
    logic [4:0]  sc_a;
    logic [31:0] sc_scaled;
    logic [31:0] sc_t;
    logic [4:0]  sc_top;
    logic [4:0]  sc_sh;
    logic [7:0]  sc_man;
    logic [8:0]  sc_exp_sum;
    logic [7:0]  sc_exp;

    // Accumulate.
    logic [4:0]  ac_kmax;
    logic [4:0]  ac_k;
    logic [31:0] ac_ib0;
    logic [7:0]  ac_is;
    logic [8:0]  ac_d;
    logic [31:0] ac_ib;
    logic [31:0] ac_am;
    logic [8:0]  ac_ae;
    logic [32:0] ac_sum;

    always_comb begin
        // Load.
        ld_top = sfmu_pkg::top_bit32(r_in_value);
        ld_sh  = (|r_in_value[31:8]) ? ld_top - 5'(sfmu_pkg::MAN_TOP_POS) : 5'd0;
        ld_man = 8'(r_in_value >> ld_sh);

        // Shift.
        m_top      = sfmu_pkg::top_bit8(r_man);
        sh_room    = 3'(sfmu_pkg::MAN_TOP_POS) - m_top;
        sh_k       = (r_in_amount >= {5'd0, sh_room}) ? sh_room : r_in_amount[2:0];
        sh_man     = r_man << sh_k;
        sh_exp_sum = {1'b0, r_exp} + {1'b0, r_in_amount - {5'd0, sh_k}};
        sh_exp     = sh_exp_sum[8] ? sfmu_pkg::EXP_MAX : sh_exp_sum[7:0];

        // Scaled self add: the scaled copy stays below 2^31.
        sc_a = (r_in_amount > {3'd0, sfmu_pkg::SCALE_MAX_AMT})
             ? sfmu_pkg::SCALE_MAX_AMT : r_in_amount[4:0];
        if (sc_a < sfmu_pkg::SCALE_BIAS) begin
            sc_scaled = {24'd0, r_man >> (sfmu_pkg::SCALE_BIAS - sc_a)};
        end else begin
            sc_scaled = {24'd0, r_man} << (sc_a - sfmu_pkg::SCALE_BIAS);
        end
        sc_t       = sc_scaled + {24'd0, r_man};
        sc_top     = sfmu_pkg::top_bit32(sc_t);
        sc_sh      = (|sc_t[31:8]) ? sc_top - 5'(sfmu_pkg::MAN_TOP_POS) : 5'd0;
        sc_man     = 8'(sc_t >> sc_sh);
        sc_exp_sum = {1'b0, r_exp} + {4'd0, sc_sh};
        sc_exp     = sc_exp_sum[8] ? sfmu_pkg::EXP_MAX : sc_exp_sum[7:0];

        // Accumulate: widen the merit, trading exponent for mantissa bits.
        ac_kmax = 5'd31 - {2'd0, m_top};
        ac_k    = (r_exp > {3'd0, ac_kmax}) ? ac_kmax : r_exp[4:0];
        if (r_man == 8'd0) begin
            ac_ib0 = 32'd0;
            ac_is  = 8'd0;
        end else begin
            ac_ib0 = {24'd0, r_man} << ac_k;
            ac_is  = r_exp - {3'd0, ac_k};
        end
        // Align the operand with the smaller exponent; 32 or more clears it.
        if ({1'b0, ac_is} <= r_acc_exp) begin
            ac_d  = r_acc_exp - {1'b0, ac_is};
            ac_ib = (ac_d >= 9'd32) ? 32'd0 : ac_ib0 >> ac_d[4:0];
            ac_am = r_acc_man;
            ac_ae = r_acc_exp;
        end else begin
            ac_d  = {1'b0, ac_is} - r_acc_exp;
            ac_ib = ac_ib0;
            ac_am = (ac_d >= 9'd32) ? 32'd0 : r_acc_man >> ac_d[4:0];
            ac_ae = {1'b0, ac_is};
        end
        ac_sum = {1'b0, ac_am} + {1'b0, ac_ib};

        n_man     = r_man;
        n_exp     = r_exp;
        n_acc_man = r_acc_man;
        n_acc_exp = r_acc_exp;
        case (r_in_mode)
            sfmu_pkg::MODE_LOAD: begin
                n_man = ld_man;
                n_exp = {3'd0, ld_sh};
            end
            sfmu_pkg::MODE_SHIFT: begin
                // A zero mantissa absorbs the whole shift.
                if (r_man != 8'd0) begin
                    n_man = sh_man;
                    n_exp = sh_exp;
                end
            end
            sfmu_pkg::MODE_SCALE: begin
                n_man = sc_man;
                n_exp = sc_exp;
            end
            default: begin
                n_acc_exp = ac_ae;
                if (!ac_sum[32]) begin
                    n_acc_man = ac_sum[31:0];
                end else if (ac_ae == sfmu_pkg::ACC_EXP_MAX) begin
                    n_acc_man = '1;
                end else begin
                    // On carry both operands are halved before the add.
                    n_acc_man = (ac_am >> 1) + (ac_ib >> 1);
                    n_acc_exp = ac_ae + 9'd1;
                end
            end
        endcase

        if (n_exp != 8'd0) begin
            n_ilog = {1'b0, n_exp} + 9'(sfmu_pkg::MAN_TOP_POS);
        end else if (n_man == 8'd0) begin
            n_ilog = 9'd0;
        end else begin
            n_ilog = {6'd0, sfmu_pkg::top_bit8(n_man)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_man       <= 8'd0;
            r_exp       <= 8'd0;
            r_acc_man   <= 32'd0;
            r_acc_exp   <= 9'd0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (exec_fire) begin
                r_in_valid <= 1'b0;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
                r_man       <= n_man;
                r_exp       <= n_exp;
                r_acc_man   <= n_acc_man;
                r_acc_exp   <= n_acc_exp;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_mode   <= sfmu_pkg::t_mode'(i_mode);
            r_in_value  <= i_value;
            r_in_amount <= i_amount;
        end
        if (exec_fire) begin
            r_out_man     <= n_man;
            r_out_exp     <= n_exp;
            r_out_ilog    <= n_ilog;
            r_out_sum_man <= n_acc_man;
            r_out_sum_exp <= n_acc_exp;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_merit_mantissa = r_out_man;
    assign o_merit_exponent = r_out_exp;
    assign o_integer_log    = r_out_ilog;
    assign o_sum_mantissa   = r_out_sum_man;
    assign o_sum_exponent   = r_out_sum_exp;

    // A nonzero exponent always comes with a normalized mantissa.
    `SFMU_ASSERT(a_merit_normalized, i_clk, i_rst_n, (r_exp == 8'd0) || r_man[7])

    // The accumulator exponent never goes down outside reset.
    `SFMU_ASSERT(a_acc_exp_grows, i_clk, i_rst_n, $past(i_rst_n) |-> r_acc_exp >= $past(r_acc_exp))

    // Accumulating leaves the merit untouched.
    `SFMU_ASSERT(a_accum_keeps_man, i_clk, i_rst_n, accum_fire |=> $stable(r_man))
    `SFMU_ASSERT(a_accum_keeps_exp, i_clk, i_rst_n, accum_fire |=> $stable(r_exp))

    // The integer log stays within its range.
    `SFMU_ASSERT(a_ilog_range, i_clk, i_rst_n, r_out_valid |-> (r_out_ilog <= 9'd262))

endmodule
